>>> hw/rtl/spirv_entry_stage_detector_top_assert.svh
// Assertion macros for the entry stage detector. Each checks on the rising
// edge of clk and is held off while rst_n is low.
`ifndef SPIRV_ENTRY_STAGE_DETECTOR_TOP_ASSERT_SVH
`define SPIRV_ENTRY_STAGE_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SPIRV_ESD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spirv_esd: assertion failed");
`define SPIRV_ESD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spirv_esd: implication failed");
`else
`define SPIRV_ESD_ASSERT(label, prop)
`define SPIRV_ESD_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

>>> hw/rtl/spirv_esd_pkg.sv
package spirv_esd_pkg;

    localparam logic [31:0] SpvMagic     = 32'h0723_0203;
    localparam logic [15:0] OpEntryPoint = 16'd15;
    localparam logic [2:0]  HeaderWords  = 3'd5;
    localparam logic [2:0]  ShortLimit   = 3'd4;

    localparam logic [3:0] StageNone     = 4'd0;
    localparam logic [3:0] StageVertex   = 4'd1;
    localparam logic [3:0] StageTessCtrl = 4'd2;
    localparam logic [3:0] StageTessEval = 4'd3;
    localparam logic [3:0] StageGeometry = 4'd4;
    localparam logic [3:0] StageFragment = 4'd5;
    localparam logic [3:0] StageCompute  = 4'd6;
    localparam logic [3:0] StageTaskNv   = 4'd7;
    localparam logic [3:0] StageTaskExt  = 4'd8;
    localparam logic [3:0] StageMeshNv   = 4'd9;
    localparam logic [3:0] StageMeshExt  = 4'd10;

    localparam logic [31:0] ModelVertex   = 32'd0;
    localparam logic [31:0] ModelTessCtrl = 32'd1;
    localparam logic [31:0] ModelTessEval = 32'd2;
    localparam logic [31:0] ModelGeometry = 32'd3;
    localparam logic [31:0] ModelFragment = 32'd4;
    localparam logic [31:0] ModelCompute  = 32'd5;
    localparam logic [31:0] ModelTaskNv   = 32'd5267;
    localparam logic [31:0] ModelTaskExt  = 32'd5364;
    localparam logic [31:0] ModelMeshNv   = 32'd5268;
    localparam logic [31:0] ModelMeshExt  = 32'd5365;

    typedef enum logic [1:0] {
        StatusFound,
        StatusBadMagic,
        StatusZeroLength,
        StatusNoStage
    } scan_status_t;

    typedef enum logic [1:0] {
        FaultNone,
        FaultBadMagic,
        FaultZeroLength
    } fault_t;

    typedef struct packed {
        logic [3:0]   stage_code;
        scan_status_t scan_status;
    } result_t;

    function automatic logic [3:0] model_to_stage(input logic [31:0] model);
        logic [3:0] stage;
        case (model)
            ModelVertex:   stage = StageVertex;
            ModelTessCtrl: stage = StageTessCtrl;
            ModelTessEval: stage = StageTessEval;
            ModelGeometry: stage = StageGeometry;
            ModelFragment: stage = StageFragment;
            ModelCompute:  stage = StageCompute;
            ModelTaskNv:   stage = StageTaskNv;
            ModelTaskExt:  stage = StageTaskExt;
            ModelMeshNv:   stage = StageMeshNv;
            ModelMeshExt:  stage = StageMeshExt;
            default:       stage = StageNone;
        endcase
        return stage;
    endfunction

endpackage

>>> hw/rtl/spirv_esd_in_if.sv
interface spirv_esd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_word;
    logic        last_word;

    modport source (output valid, output code_word, output last_word, input ready);
    modport sink (input valid, input code_word, input last_word, output ready);
endinterface

>>> hw/rtl/spirv_esd_out_if.sv
interface spirv_esd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] stage_code;
    logic [1:0] scan_status;

    modport source (output valid, output stage_code, output scan_status, input ready);
    modport sink (input valid, input stage_code, input scan_status, output ready);
endinterface

>>> hw/rtl/spirv_esd_scan.sv
module spirv_esd_scan
    import spirv_esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [31:0] code_word,
    input  logic        last_word,
    output logic        res_valid,
    output result_t     res
);

    logic [2:0]  header_pos_reg, header_pos_next;
    logic [15:0] skip_reg, skip_next;
    logic        expect_model_reg, expect_model_next;
    logic [3:0]  stage_reg, stage_next;
    fault_t      fault_reg, fault_next;
    logic        short_module;

    always_comb
    begin
        header_pos_next   = header_pos_reg;
        skip_next         = skip_reg;
        expect_model_next = expect_model_reg;
        stage_next        = stage_reg;
        fault_next        = fault_reg;
        short_module      = 1'b0;

        if (fault_reg == FaultNone)
        begin
            if (header_pos_reg < HeaderWords)
            begin
                if (header_pos_reg == 3'd0 && code_word != SpvMagic)
                begin
                    fault_next = FaultBadMagic;
                end
                if (last_word && header_pos_reg < ShortLimit)
                begin
                    short_module = 1'b1;
                end
                header_pos_next = header_pos_reg + 3'd1;
            end
            else
            begin
                // A one-word entry point makes this word both the model and
                // the next instruction, so the model is read before decoding.
                if (expect_model_reg)
                begin
                    stage_next        = model_to_stage(code_word);
                    expect_model_next = 1'b0;
                end
                if (skip_reg != 16'd0)
                begin
                    skip_next = skip_reg - 16'd1;
                end
                else
                begin
                    if (code_word[15:0] == OpEntryPoint)
                    begin
                        expect_model_next = 1'b1;
                    end
                    if (code_word[31:16] == 16'd0)
                    begin
                        fault_next = FaultZeroLength;
                    end
                    else
                    begin
                        skip_next = code_word[31:16] - 16'd1;
                    end
                end
            end
        end

        res.stage_code = StageNone;
        if (short_module || fault_next == FaultBadMagic)
        begin
            res.scan_status = StatusBadMagic;
        end
        else if (fault_next == FaultZeroLength)
        begin
            res.scan_status = StatusZeroLength;
        end
        else if (stage_next != StageNone)
        begin
            res.scan_status = StatusFound;
            res.stage_code  = stage_next;
        end
        else
        begin
            res.scan_status = StatusNoStage;
        end

        res_valid = accept && last_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= 3'd0;
            skip_reg         <= 16'd0;
            expect_model_reg <= 1'b0;
            stage_reg        <= StageNone;
            fault_reg        <= FaultNone;
        end
        else if (accept)
        begin
            // The last word closes the module and the scan starts afresh.
            if (last_word)
            begin
                header_pos_reg   <= 3'd0;
                skip_reg         <= 16'd0;
                expect_model_reg <= 1'b0;
                stage_reg        <= StageNone;
                fault_reg        <= FaultNone;
            end
            else
            begin
                header_pos_reg   <= header_pos_next;
                skip_reg         <= skip_next;
                expect_model_reg <= expect_model_next;
                stage_reg        <= stage_next;
                fault_reg        <= fault_next;
            end
        end
    end

endmodule

>>> hw/rtl/spirv_esd_out_buf.sv
module spirv_esd_out_buf
    import spirv_esd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  result_t          push_data,
    output logic             room,
    spirv_esd_out_if.source  result
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop                = main_valid_reg && result.ready;
    assign room               = !skid_valid_reg;
    assign result.valid       = main_valid_reg;
    assign result.stage_code  = main_data_reg.stage_code;
    assign result.scan_status = main_data_reg.scan_status;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // No push can arrive here, as room is low while the skid is full.
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> hw/rtl/spirv_entry_stage_detector_top.sv
// Channel  Modport  Payload                     Transfer when
// words    sink     code_word[31:0], last_word  valid && ready
// result   source   stage_code[3:0], scan_status[1:0]  valid && ready
//
// One word is taken in every cycle while words.ready is high; the scan state updates in the same cycle.
// The result of a module is registered in the output buffer: its main entry, or its skid entry while main is held.
// A two-entry output buffer lets words keep flowing while a result waits.
// words.ready falls only when both output entries are held by a stalled sink.
// Reset clears the scan state and empties the output buffer.
`include "spirv_entry_stage_detector_top_assert.svh"

module spirv_entry_stage_detector_top
    import spirv_esd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    spirv_esd_in_if.sink    words,
    spirv_esd_out_if.source result
);

    logic    accept;
    logic    room;
    logic    res_valid;
    result_t res;

    assign words.ready = room;
    assign accept      = words.valid && room;

    spirv_esd_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_word (words.code_word),
        .last_word (words.last_word),
        .res_valid (res_valid),
        .res       (res)
    );

    spirv_esd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .result    (result)
    );

    `SPIRV_ESD_ASSERT_IMPLY(a_push_on_last, res_valid, accept && words.last_word)
    `SPIRV_ESD_ASSERT_IMPLY(a_stall_needs_result, !words.ready, result.valid)
    `SPIRV_ESD_ASSERT_IMPLY(a_stage_only_when_found, result.valid && result.scan_status != StatusFound, result.stage_code == StageNone)
    `SPIRV_ESD_ASSERT_IMPLY(a_found_has_stage, result.valid && result.scan_status == StatusFound, result.stage_code != StageNone)

endmodule
